@@ rtl/fire_effect_tile_update_top_defines.svh @@
// ----------------------------------------------------------------------------
// Fire tile assertion macros
// Concurrent assertion helpers shared by the fire tile RTL.
// ----------------------------------------------------------------------------
`ifndef FIRE_EFFECT_TILE_UPDATE_TOP_DEFINES_SVH
`define FIRE_EFFECT_TILE_UPDATE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define FET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define FET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FET_ASSERT(lbl, prop, msg)
`define FET_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/fet_pkg.sv @@
// ----------------------------------------------------------------------------
// Fire tile package
// Types, constants and the random bit generator step of the fire tile.
// ----------------------------------------------------------------------------
package fet_pkg;

  localparam int TILE_SIDE_DEF = 64;
  localparam int NUM_RD        = 7;

  localparam logic [7:0]  BG_LEVEL      = 8'd96;
  localparam logic [7:0]  DECAY_MIN     = 8'd158;
  localparam logic [7:0]  IGNITE_MAX    = 8'd159;
  localparam logic [7:0]  SHOW_BG       = 8'd255;
  localparam logic [7:0]  SPARK_LVL_RST = 8'd175;
  localparam logic [31:0] RAND_SEED     = 32'h41C6167E;
  localparam logic [4:0]  RAND_CNT_RST  = 5'd31;

  typedef enum logic {
    REQ_PIXEL  = 1'b0,
    REQ_COMMIT = 1'b1
  } req_e;

  typedef enum logic {
    CFG_ENABLE = 1'b0,
    CFG_SPARK  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic        rbit;
    logic [31:0] word;
    logic [4:0]  cnt;
  } fet_draw_t;

  function automatic fet_draw_t fet_draw(input logic [31:0] word, input logic [4:0] cnt);
    fet_draw_t  r;
    logic [4:0] c;
    r.rbit = word[0];
    c = cnt - 5'd1;
    if (c != 5'd0) begin
      r.word = {word[0], word[31:1]};
      r.cnt  = c;
    end else begin
      r.word = word ^ (word >> 4);
      r.cnt  = RAND_CNT_RST;
    end
    return r;
  endfunction

endpackage

@@ rtl/fet_field.sv @@
// ----------------------------------------------------------------------------
// Fire tile field storage
// Two field banks, each kept in several copies so that the seven-cell
// neighborhood of one pixel is read in parallel.
// ----------------------------------------------------------------------------
module fet_field import fet_pkg::*; #(
  parameter int TILE_SIDE = TILE_SIDE_DEF,
  localparam int FSIDE    = TILE_SIDE + 2,
  localparam int FCELLS   = FSIDE * FSIDE,
  localparam int AW       = $clog2(FCELLS)
) (
  input  logic          clk_i,
  input  logic [1:0]    wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic          rd_bank_i,
  input  logic [AW-1:0] rd_addr_i [NUM_RD],
  output logic [7:0]    rd_data_o [NUM_RD]
);

  localparam int NUM_COPY = (NUM_RD + 1) / 2;

  logic       rd_bank_q;
  logic [7:0] bank_rd [2][NUM_RD];

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_bank_q <= rd_bank_i;
    end
  end

  for (genvar b = 0; b < 2; b++) begin : g_bank
    for (genvar k = 0; k < NUM_COPY; k++) begin : g_copy
      logic [7:0] mem_q [FCELLS];
      logic [7:0] rd_lo_q;

      always_ff @(posedge clk_i) begin
        if (wr_en_i[b]) begin
          mem_q[wr_addr_i] <= wr_data_i;
        end
      end

      always_ff @(posedge clk_i) begin
        if (rd_en_i) begin
          rd_lo_q <= mem_q[rd_addr_i[2*k]];
        end
      end

      assign bank_rd[b][2*k] = rd_lo_q;

      if (2 * k + 1 < NUM_RD) begin : g_hi
        logic [7:0] rd_hi_q;

        always_ff @(posedge clk_i) begin
          if (rd_en_i) begin
            rd_hi_q <= mem_q[rd_addr_i[2*k+1]];
          end
        end

        assign bank_rd[b][2*k+1] = rd_hi_q;
      end
    end
  end

  for (genvar k = 0; k < NUM_RD; k++) begin : g_out
    assign rd_data_o[k] = rd_bank_q ? bank_rd[1][k] : bank_rd[0][k];
  end

endmodule

@@ rtl/fire_effect_tile_update_top.sv @@
// ----------------------------------------------------------------------------
// Fire tile update
// Fire cellular automaton over a bordered two-bank byte field. Each pixel
// request computes the next interior cell in raster order; a commit request
// swaps the banks and may inject a spark.
//
//   Channel   Dir  Handshake               Content
//   s_axis    in   tvalid/tready           tuser: req_type
//                                          tdata: spark_row, spark_col
//   m_axis    out  tvalid/tready           tdata: pixel_value, pixel_index
//                                          tlast: frame_last
//   apb       in   psel/penable/pready     effect_enable, spark_level
//
// One request is accepted per cycle while no result stalls and no clearing
// pass runs; a pixel result passes the stage-1 register and then the output
// register. The field read port addresses the neighborhood at acceptance;
// the result register takes the new pixel when stage 1 advances.
// After reset a clearing pass writes the background into both banks, one cell
// a cycle, over all (TILE_SIDE+2)^2 cells (4356 at the default size); no request
// is accepted meanwhile. A stalled result holds a pixel request behind it.
// ----------------------------------------------------------------------------
`include "fire_effect_tile_update_top_defines.svh"

module fire_effect_tile_update_top import fet_pkg::*; #(
  parameter int TILE_SIDE = TILE_SIDE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [5:0] spark_row, [11:6] spark_col
  input  logic        s_axis_tuser,   // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] pixel_value, [19:8] pixel_index
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int FSIDE  = TILE_SIDE + 2;
  localparam int FCELLS = FSIDE * FSIDE;
  localparam int NPIX   = TILE_SIDE * TILE_SIDE;
  localparam int AW     = $clog2(FCELLS);
  localparam int RW     = $clog2(NPIX);
  localparam int CW     = $clog2(TILE_SIDE);

  logic            enable_q, enable_d;
  logic [7:0]      spark_lvl_q, spark_lvl_d;
  logic            bank_q, bank_d;
  logic [RW-1:0]   raster_q, raster_d;
  logic [CW-1:0]   col_q, col_d;
  logic [AW-1:0]   fpos_q, fpos_d;
  logic [15:0]     spark_cd_q, spark_cd_d;
  logic [31:0]     rand_word_q, rand_word_d;
  logic [4:0]      rand_cnt_q, rand_cnt_d;
  logic            clr_busy_q, clr_busy_d;
  logic [AW-1:0]   clr_addr_q, clr_addr_d;

  logic            s1_valid_q, s1_valid_d;
  logic            s1_commit_q;
  logic            s1_bank_q;
  logic [AW-1:0]   s1_addr_q;
  logic [1:0]      s1_we_q;
  logic [7:0]      s1_val_q;
  logic [NUM_RD-1:0] s1_hit_q;
  logic [RW-1:0]   s1_raster_q;
  logic            s1_last_q;

  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_value_q;
  logic [11:0]     out_index_q;
  logic            out_last_q;

  logic            cfg_wr;
  logic            take;
  logic            is_commit;
  logic            s1_adv;
  logic [5:0]      srow, scol;
  logic            last_pix, last_col;
  logic [AW-1:0]   rd_addr [NUM_RD];
  logic [7:0]      rd_data [NUM_RD];
  logic [7:0]      rd_val  [NUM_RD];
  logic [15:0]     cd_dec;
  logic            spark_fire, spark_in, spark_border, spark_ok;
  logic [AW-1:0]   spark_addr;
  logic [1:0]      spark_we;
  logic            fwd_en;
  logic [NUM_RD-1:0] fwd_hit;
  logic [7:0]      m_a, m_b, m_c, m_d, nmax;
  logic [7:0]      new_val;
  logic [1:0]      ndraw;
  fet_draw_t       d1, d2;
  logic [1:0]      wr_en;
  logic [AW-1:0]   wr_addr;
  logic [7:0]      wr_data;
  logic [31:0]     raster_ext;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    enable_d    = enable_q;
    spark_lvl_d = spark_lvl_q;
    if (cfg_wr) begin
      case (cfg_reg_e'(paddr[2]))
        CFG_ENABLE: enable_d    = pwdata[0];
        CFG_SPARK:  spark_lvl_d = pwdata[7:0];
        default:    enable_d    = enable_q;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_e'(paddr[2]))
      CFG_ENABLE: prdata = {31'd0, enable_q};
      CFG_SPARK:  prdata = {24'd0, spark_lvl_q};
      default:    prdata = '0;
    endcase
  end

  // Request side.
  assign s1_adv        = s1_valid_q && (s1_commit_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !clr_busy_q && (!s1_valid_q || s1_adv);
  assign take          = s_axis_tvalid && s_axis_tready && enable_q;
  assign is_commit     = (req_e'(s_axis_tuser) == REQ_COMMIT);
  assign srow          = s_axis_tdata[5:0];
  assign scol          = s_axis_tdata[11:6];
  assign last_pix      = (raster_q == RW'(NPIX - 1));
  assign last_col      = (col_q == CW'(TILE_SIDE - 1));

  assign rd_addr[0] = fpos_q;
  assign rd_addr[1] = fpos_q + AW'(1);
  assign rd_addr[2] = fpos_q - AW'(1);
  assign rd_addr[3] = fpos_q - AW'(FSIDE);
  assign rd_addr[4] = fpos_q + AW'(FSIDE);
  assign rd_addr[5] = fpos_q - AW'(FSIDE - 1);
  assign rd_addr[6] = fpos_q - AW'(FSIDE + 1);

  assign cd_dec       = spark_cd_q - 16'd1;
  assign spark_fire   = (cd_dec == 16'd0) || cd_dec[15];
  assign spark_in     = (int'(srow) < FSIDE) && (int'(scol) < FSIDE);
  assign spark_border = (srow == 6'd0) || (scol == 6'd0) ||
                        (int'(srow) == FSIDE - 1) || (int'(scol) == FSIDE - 1);
  assign spark_ok     = spark_fire && spark_in;
  assign spark_addr   = AW'(int'(srow) * FSIDE + int'(scol));
  assign spark_we     = bank_q ? {spark_ok && spark_border, spark_ok}
                               : {spark_ok, spark_ok && spark_border};

  // A spark still waiting in the write stage lands in the bank read now.
  assign fwd_en = s1_valid_q && s1_commit_q && s1_we_q[bank_q];
  for (genvar k = 0; k < NUM_RD; k++) begin : g_fwd
    assign fwd_hit[k] = fwd_en && (s1_addr_q == rd_addr[k]);
    assign rd_val[k]  = s1_hit_q[k] ? s1_val_q : rd_data[k];
  end

  fet_field #(
    .TILE_SIDE (TILE_SIDE)
  ) u_field (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (take && !is_commit),
    .rd_bank_i (bank_q),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Pixel rule.
  assign m_a  = (rd_val[1] > rd_val[2]) ? rd_val[1] : rd_val[2];
  assign m_b  = (rd_val[3] > rd_val[4]) ? rd_val[3] : rd_val[4];
  assign m_c  = (rd_val[5] > rd_val[6]) ? rd_val[5] : rd_val[6];
  assign m_d  = (m_a > m_b) ? m_a : m_b;
  assign nmax = (m_d > m_c) ? m_d : m_c;
  assign d1   = fet_draw(rand_word_q, rand_cnt_q);
  assign d2   = fet_draw(d1.word, d1.cnt);

  always_comb begin
    new_val = BG_LEVEL;
    ndraw   = 2'd0;
    if (rd_val[0] != BG_LEVEL) begin
      new_val = (rd_val[0] > DECAY_MIN) ? rd_val[0] - 8'd1 : BG_LEVEL;
    end else begin
      ndraw = 2'd1;
      if (!d1.rbit && (nmax > IGNITE_MAX)) begin
        ndraw   = 2'd2;
        new_val = d2.rbit ? nmax : nmax - 8'd1;
      end
    end
  end

  always_comb begin
    wr_en   = 2'b00;
    wr_addr = s1_addr_q;
    wr_data = s1_val_q;
    if (clr_busy_q) begin
      wr_en   = 2'b11;
      wr_addr = clr_addr_q;
      wr_data = BG_LEVEL;
    end else if (s1_adv) begin
      if (s1_commit_q) begin
        wr_en = s1_we_q;
      end else begin
        wr_en   = s1_bank_q ? 2'b01 : 2'b10;
        wr_data = new_val;
      end
    end
  end

  // State update.
  always_comb begin
    bank_d      = bank_q;
    raster_d    = raster_q;
    col_d       = col_q;
    fpos_d      = fpos_q;
    spark_cd_d  = spark_cd_q;
    rand_word_d = rand_word_q;
    rand_cnt_d  = rand_cnt_q;
    clr_busy_d  = clr_busy_q;
    clr_addr_d  = clr_addr_q;
    s1_valid_d  = s1_valid_q && !s1_adv;
    out_valid_d = out_valid_q && !m_axis_tready;

    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(FCELLS - 1)) begin
        clr_busy_d = 1'b0;
      end
    end

    if (take) begin
      s1_valid_d = 1'b1;
      if (is_commit) begin
        bank_d     = ~bank_q;
        raster_d   = '0;
        col_d      = '0;
        fpos_d     = AW'(FSIDE + 1);
        spark_cd_d = spark_fire ? 16'd1 : cd_dec;
      end else begin
        raster_d = last_pix ? '0 : raster_q + RW'(1);
        col_d    = last_col ? '0 : col_q + CW'(1);
        if (last_pix) begin
          fpos_d = AW'(FSIDE + 1);
        end else if (last_col) begin
          fpos_d = fpos_q + AW'(3);
        end else begin
          fpos_d = fpos_q + AW'(1);
        end
      end
    end

    if (s1_adv && !s1_commit_q) begin
      out_valid_d = 1'b1;
      case (ndraw)
        2'd1: begin
          rand_word_d = d1.word;
          rand_cnt_d  = d1.cnt;
        end
        2'd2: begin
          rand_word_d = d2.word;
          rand_cnt_d  = d2.cnt;
        end
        default: rand_word_d = rand_word_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b1;
      spark_lvl_q <= SPARK_LVL_RST;
      bank_q      <= 1'b0;
      raster_q    <= '0;
      col_q       <= '0;
      fpos_q      <= AW'(FSIDE + 1);
      spark_cd_q  <= 16'd0;
      rand_word_q <= RAND_SEED;
      rand_cnt_q  <= RAND_CNT_RST;
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      enable_q    <= enable_d;
      spark_lvl_q <= spark_lvl_d;
      bank_q      <= bank_d;
      raster_q    <= raster_d;
      col_q       <= col_d;
      fpos_q      <= fpos_d;
      spark_cd_q  <= spark_cd_d;
      rand_word_q <= rand_word_d;
      rand_cnt_q  <= rand_cnt_d;
      clr_busy_q  <= clr_busy_d;
      clr_addr_q  <= clr_addr_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_commit_q <= is_commit;
      s1_bank_q   <= bank_q;
      s1_addr_q   <= is_commit ? spark_addr : fpos_q;
      s1_we_q     <= is_commit ? spark_we : 2'b00;
      s1_val_q    <= is_commit ? spark_lvl_q : s1_val_q;
      s1_hit_q    <= is_commit ? '0 : fwd_hit;
      s1_raster_q <= raster_q;
      s1_last_q   <= last_pix;
    end
  end

  assign raster_ext = 32'(s1_raster_q);

  always_ff @(posedge clk_i) begin
    if (s1_adv && !s1_commit_q) begin
      out_value_q <= (new_val == BG_LEVEL) ? SHOW_BG : new_val;
      out_index_q <= raster_ext[11:0];
      out_last_q  <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_index_q, out_value_q};
  assign m_axis_tlast  = out_last_q;

  `FET_ASSERT(a_clear_empty, clr_busy_q |-> !s1_valid_q && !out_valid_q, "request in flight during clear")
  `FET_ASSERT_NEXT(a_pixel_result, s1_adv && !s1_commit_q, m_axis_tvalid, "pixel result lost")
  `FET_ASSERT_NEXT(a_commit_rewind, take && is_commit, raster_q == '0 && col_q == '0, "commit did not rewind")

endmodule
